@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the line start index unit.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted (active low).
`define LSI_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked property that also holds during reset.
`define LSI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lsi_pkg.sv @@
// Package of the line start index unit: item types, operation codes, states, constants.
// No dependencies.
package lsi_pkg;

    localparam int DEF_MAX_LINES   = 4096;
    localparam int DEF_OFFSET_BITS = 24;

    localparam int BYTE_W = 8;
    localparam int OFS_W  = 24;
    localparam int LINE_W = 12;
    localparam int CNT_W  = 13;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_BYTE    = 2'd1,
        OP_FIND    = 2'd2,
        OP_RANGE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RANGE,
        S_RANGE_END,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] char_byte;
        logic [OFS_W-1:0]  query_offset;
        logic [LINE_W-1:0] query_line;
    } t_in_item;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [OFS_W-1:0]  range_start;
        logic [OFS_W-1:0]  range_end;
        logic [OFS_W-1:0]  range_end_with_newline;
        logic [CNT_W-1:0]  lines_held;
        logic              table_overflow;
    } t_out_item;

endpackage

@@ rtl/core/lsi_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/line_start_index_unit.sv @@
// Top level of the line start index unit: control, search sequencer and result register.
// Depends on lsi_pkg and lsi_ram.
//
// The unit keeps a table of line start offsets for a text that arrives one byte per item.
// A restart item resets the table to one line starting at offset 0, with text length 0
// and the overflow flag clear. A text byte item advances the text length by one; a
// newline byte also appends the following offset as a new line start, or, with the table
// already full, is dropped from the table and sets the overflow flag. Once the text length
// reaches its largest value, further byte items are ignored. A line-from-offset item
// returns the last line whose start is not above the offset; a line-range item clamps the
// line number to the last line and returns its start, its end without the newline and its
// end with the newline (the last line ends at the text length). Restart and byte items
// give no result. A line-from-offset item makes at most ceil(log2(lines held)) search
// probes, none with one line: the table sits in a single RAM with one read port and
// registered read data, and the binary search issues one probe per cycle, choosing the
// next address from the data just read. A line-range item needs one read of the same RAM
// on the last line and two otherwise. Every result passes through an output register, so
// the next item is accepted while a result still waits to be taken. No clearing pass is
// needed after reset: table entry zero reads as 0 by construction and other entries are
// used only once written.
module line_start_index_unit #(
    parameter int MAX_LINES   = lsi_pkg::DEF_MAX_LINES,
    parameter int OFFSET_BITS = lsi_pkg::DEF_OFFSET_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lsi_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lsi_pkg::t_out_item o_out_item
);

    // Widths: line index, line count, compare width for offsets and for line numbers.
    localparam int IW    = $clog2(MAX_LINES);
    localparam int CW    = $clog2(MAX_LINES + 1);
    localparam int CMP_W = (OFFSET_BITS > lsi_pkg::OFS_W) ? OFFSET_BITS : lsi_pkg::OFS_W;
    localparam int QW    = (CW > lsi_pkg::LINE_W) ? CW : lsi_pkg::LINE_W;

    // Architectural state
    lsi_pkg::t_state   r_state, n_state;
    logic [CW-1:0]     r_total;
    logic [OFFSET_BITS-1:0] r_len;
    logic              r_ovf;

    // Search and range working registers
    logic [IW-1:0]     r_lo, r_hi, r_mid;
    logic [IW-1:0]     r_line;
    logic [lsi_pkg::OFS_W-1:0] r_qoff;
    logic [OFFSET_BITS-1:0]    r_rs;

    // Pending result and output register
    lsi_pkg::t_out_item r_res, n_res;
    logic               res_load;
    lsi_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic               out_load;

    // RAM ports
    logic                   ram_wr_en;
    logic [IW-1:0]          ram_wr_addr;
    logic [OFFSET_BITS-1:0] ram_wr_data;
    logic [IW-1:0]          ram_rd_addr;
    logic [OFFSET_BITS-1:0] ram_rd_data;

    // Datapath terms
    logic          in_acc;
    logic [CW-1:0] total_m1;
    logic [IW-1:0] clamp_line;
    logic          len_full;
    logic          is_newline;
    logic          has_room;
    logic          probe_le;
    logic [IW-1:0] new_lo, new_hi, new_mid;
    logic [IW:0]   span;
    logic          search_done;
    logic [OFFSET_BITS-1:0] rs_now;
    logic          line_is_last;

    lsi_ram #(
        .WIDTH (OFFSET_BITS),
        .DEPTH (MAX_LINES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_in_ready = (r_state == lsi_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign total_m1   = r_total - CW'(1);
    // Clamp the asked line to the last line held
    assign clamp_line = (QW'(i_in_item.query_line) < QW'(total_m1))
                        ? IW'(i_in_item.query_line) : IW'(total_m1);

    assign len_full   = &r_len;
    assign is_newline = (i_in_item.char_byte == lsi_pkg::NEWLINE_BYTE);
    assign has_room   = (r_total < CW'(MAX_LINES));

    // One search step: the probe at r_mid has just come back from the RAM
    assign probe_le    = (CMP_W'(ram_rd_data) <= CMP_W'(r_qoff));
    assign new_lo      = probe_le ? r_mid : r_lo;
    assign new_hi      = probe_le ? r_hi : (r_mid - IW'(1));
    assign search_done = (new_lo == new_hi);
    assign span        = (IW + 1)'(new_hi) - (IW + 1)'(new_lo) + (IW + 1)'(1);
    assign new_mid     = new_lo + IW'(span >> 1);

    // Entry zero is never stored: it always reads as offset 0
    assign rs_now       = (r_line == '0) ? '0 : ram_rd_data;
    assign line_is_last = (CW'(r_line) == total_m1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsi_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.op)
                        lsi_pkg::OP_FIND: begin
                            n_state = (r_total == CW'(1)) ? lsi_pkg::S_PUSH
                                                          : lsi_pkg::S_SEARCH;
                        end
                        lsi_pkg::OP_RANGE: n_state = lsi_pkg::S_RANGE;
                        default:           n_state = lsi_pkg::S_IDLE;
                    endcase
                end
            end
            lsi_pkg::S_SEARCH: begin
                if (search_done) begin
                    n_state = lsi_pkg::S_PUSH;
                end
            end
            lsi_pkg::S_RANGE: begin
                n_state = line_is_last ? lsi_pkg::S_PUSH : lsi_pkg::S_RANGE_END;
            end
            lsi_pkg::S_RANGE_END: n_state = lsi_pkg::S_PUSH;
            lsi_pkg::S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = lsi_pkg::S_IDLE;
                end
            end
            default: n_state = lsi_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM access and result assembly
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = IW'(r_total);
        ram_wr_data = r_len + OFFSET_BITS'(1);
        ram_rd_addr = r_mid;
        res_load    = 1'b0;
        out_load    = 1'b0;
        n_res                        = '0;
        n_res.lines_held             = lsi_pkg::CNT_W'(r_total);
        n_res.table_overflow         = r_ovf;
        case (r_state)
            lsi_pkg::S_IDLE: begin
                // Append a line start on a newline that still fits
                ram_wr_en   = in_acc && (i_in_item.op == lsi_pkg::OP_BYTE) && !len_full
                              && is_newline && has_room;
                ram_rd_addr = (i_in_item.op == lsi_pkg::OP_RANGE) ? clamp_line
                                                                   : IW'(r_total >> 1);
                // A single line answers a lookup at once
                res_load    = in_acc && (i_in_item.op == lsi_pkg::OP_FIND)
                              && (r_total == CW'(1));
            end
            lsi_pkg::S_SEARCH: begin
                ram_rd_addr       = new_mid;
                res_load          = search_done;
                n_res.line_number = lsi_pkg::LINE_W'(new_lo);
            end
            lsi_pkg::S_RANGE: begin
                ram_rd_addr                  = r_line + IW'(1);
                res_load                     = line_is_last;
                n_res.line_number            = lsi_pkg::LINE_W'(r_line);
                n_res.range_start            = lsi_pkg::OFS_W'(rs_now);
                n_res.range_end              = lsi_pkg::OFS_W'(r_len);
                n_res.range_end_with_newline = lsi_pkg::OFS_W'(r_len);
            end
            lsi_pkg::S_RANGE_END: begin
                res_load                     = 1'b1;
                n_res.line_number            = lsi_pkg::LINE_W'(r_line);
                n_res.range_start            = lsi_pkg::OFS_W'(r_rs);
                n_res.range_end              = lsi_pkg::OFS_W'(ram_rd_data - OFFSET_BITS'(1));
                n_res.range_end_with_newline = lsi_pkg::OFS_W'(ram_rd_data);
            end
            lsi_pkg::S_PUSH: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                ram_rd_addr = r_mid;
            end
        endcase
    end

    // Control state and table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsi_pkg::S_IDLE;
            r_total     <= CW'(1);
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                case (i_in_item.op)
                    lsi_pkg::OP_RESTART: begin
                        r_total <= CW'(1);
                        r_len   <= '0;
                        r_ovf   <= 1'b0;
                    end
                    lsi_pkg::OP_BYTE: begin
                        // Drop the byte once the length has saturated
                        if (!len_full) begin
                            r_len <= r_len + OFFSET_BITS'(1);
                            if (is_newline) begin
                                if (has_room) begin
                                    r_total <= r_total + CW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        r_len <= r_len;
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and payload: no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lo   <= '0;
            r_hi   <= IW'(total_m1);
            r_mid  <= IW'(r_total >> 1);
            r_qoff <= i_in_item.query_offset;
            r_line <= clamp_line;
        end else if (r_state == lsi_pkg::S_SEARCH) begin
            r_lo  <= new_lo;
            r_hi  <= new_hi;
            r_mid <= new_mid;
        end
        if (r_state == lsi_pkg::S_RANGE) begin
            r_rs <= rs_now;
        end
        if (res_load) begin
            r_res <= n_res;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ rtl/core/lsi_checker.sv @@
// Port-level checker of the line start index unit, bound to the top level.
// Depends on lsi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input lsi_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lsi_pkg::t_out_item o_out_item
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // A waiting result holds until taken
    `LSI_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "result dropped or changed while stalled")

    // The table always holds at least one line
    `LSI_ASSERT_RST(a_lines_nonzero, i_clk, i_rst_n, o_out_valid |-> (o_out_item.lines_held != '0), "result reports an empty table")

    // End with newline is the end itself or one past it
    `LSI_ASSERT_RST(a_end_pair, i_clk, i_rst_n, o_out_valid |-> ((o_out_item.range_end_with_newline == o_out_item.range_end) || (o_out_item.range_end_with_newline == o_out_item.range_end + 24'd1)), "line end pair inconsistent")

    // A query never yields a result in the cycle after it is taken
    `LSI_ASSERT_RST(a_no_instant_result, i_clk, i_rst_n, in_acc && !o_out_valid && ((i_in_item.op == lsi_pkg::OP_FIND) || (i_in_item.op == lsi_pkg::OP_RANGE)) |=> !o_out_valid, "result appeared too early")

    // Nothing is offered straight after reset
    `LSI_ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(i_rst_n) == 1'b0 |-> !o_out_valid, "result valid after reset")

endmodule

bind line_start_index_unit lsi_checker u_lsi_checker (.*);
